// ----- hdl/double_ended_queue_macros.svh -----
// Assertion helpers used by the checker file.
`ifndef DOUBLE_ENDED_QUEUE_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_MACROS_SVH

// Same-cycle implication.
`define DEQ_ASSERT_IMP(lbl, clk, rst, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("deque port check failed");

// Next-cycle implication.
`define DEQ_ASSERT_NXT(lbl, clk, rst, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("deque port check failed");

`endif

// ----- hdl/deq_pkg.sv -----
package deq_pkg;

  localparam int DEPTH_DEFAULT = 16;
  localparam int DATA_W        = 32;
  localparam int IN_TDATA_W    = 40;
  localparam int OUT_TDATA_W   = 72;
  localparam int COUNT_W       = 5;

  typedef enum logic [1:0] {
    OP_PUSH_BACK  = 2'd0,
    OP_PUSH_FRONT = 2'd1,
    OP_POP_BACK   = 2'd2,
    OP_POP_FRONT  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_UNDERFLOW = 2'd1,
    STAT_OVERFLOW  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_LOAD
  } state_t;

endpackage

// ----- hdl/deq_store.sv -----
module deq_store #(
  parameter int DEPTH = deq_pkg::DEPTH_DEFAULT,
  parameter int AW    = $clog2(deq_pkg::DEPTH_DEFAULT),
  parameter int DW    = deq_pkg::DATA_W
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic [AW-1:0] rd_addr_a,
  input  logic [AW-1:0] rd_addr_b,
  output logic [DW-1:0] rd_data_a,
  output logic [DW-1:0] rd_data_b
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end

endmodule

// ----- hdl/double_ended_queue.sv -----
// Bounded double-ended queue of signed 32-bit values held in a DEPTH-entry
// circular store (head pointer plus count). Each input item carries an
// operation (push back, push front, pop back, pop front) and a value, and
// gives one result with the front and back values, empty flag, count and
// status. An item passes through accept (pointer update and store write),
// store read of front and back, and result load, in that order; the store
// read is registered, and the load waits while the output is stalled.
// A new item is taken while the previous result waits at the output. No
// clearing pass after reset: entries are only read once written.
module double_ended_queue #(
  parameter int DEPTH = deq_pkg::DEPTH_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // op [1:0], data_in [33:2], zero fill [39:34]
  input  logic [deq_pkg::IN_TDATA_W-1:0]   s_tdata,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // front_value [31:0], back_value [63:32], empty_flag [64],
  // entry_count [69:65], status [71:70]
  output logic [deq_pkg::OUT_TDATA_W-1:0]  m_tdata
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = AW + 1;
  localparam int DW = deq_pkg::DATA_W;
  localparam logic [SW-1:0] DEPTH_S = SW'(DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic [AW-1:0] LAST_A  = AW'(DEPTH - 1);

  deq_pkg::state_t  state, state_next;
  logic [AW-1:0]    head, head_next;
  logic [CW-1:0]    count, count_next;
  deq_pkg::status_t status, status_next;

  deq_pkg::op_t     op;
  logic [DW-1:0]    din;
  logic             accept, full, empty, load_out;
  logic             wr_en;
  logic [AW-1:0]    wr_addr, push_slot, head_dec, head_inc, back_slot;
  logic [DW-1:0]    rd_front, rd_back;

  // sum is below twice the depth, so one compare and subtract wraps it
  function automatic logic [AW-1:0] wrap(input logic [SW-1:0] s);
    logic [SW-1:0] r;
    r = (s >= DEPTH_S) ? s - DEPTH_S : s;
    return r[AW-1:0];
  endfunction

  assign op     = deq_pkg::op_t'(s_tdata[1:0]);
  assign din    = s_tdata[33:2];
  assign accept = s_tvalid && s_tready;
  assign full   = (count == DEPTH_C);
  assign empty  = (count == '0);

  assign push_slot = wrap(SW'(head) + SW'(count));
  assign back_slot = wrap(SW'(head) + SW'(count) - SW'(1));
  assign head_dec  = (head == '0) ? LAST_A : head - AW'(1);
  assign head_inc  = (head == LAST_A) ? '0 : head + AW'(1);

  // pointer, count, status and store write for the item being accepted
  always_comb begin
    head_next   = head;
    count_next  = count;
    status_next = deq_pkg::STAT_OK;
    wr_en       = 1'b0;
    wr_addr     = push_slot;
    unique case (op)
      deq_pkg::OP_PUSH_BACK: begin
        if (full) begin
          status_next = deq_pkg::STAT_OVERFLOW;
        end else begin
          wr_en      = accept;
          count_next = count + CW'(1);
        end
      end
      deq_pkg::OP_PUSH_FRONT: begin
        wr_addr = head_dec;
        if (full) begin
          status_next = deq_pkg::STAT_OVERFLOW;
        end else begin
          wr_en      = accept;
          head_next  = head_dec;
          count_next = count + CW'(1);
        end
      end
      deq_pkg::OP_POP_BACK: begin
        if (empty) begin
          status_next = deq_pkg::STAT_UNDERFLOW;
        end else begin
          count_next = count - CW'(1);
        end
      end
      deq_pkg::OP_POP_FRONT: begin
        if (empty) begin
          status_next = deq_pkg::STAT_UNDERFLOW;
        end else begin
          head_next  = head_inc;
          count_next = count - CW'(1);
        end
      end
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      deq_pkg::S_IDLE: if (s_tvalid) state_next = deq_pkg::S_READ;
      deq_pkg::S_READ: state_next = deq_pkg::S_LOAD;
      deq_pkg::S_LOAD: if (!m_tvalid || m_tready) state_next = deq_pkg::S_IDLE;
      default:         state_next = deq_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    s_tready = (state == deq_pkg::S_IDLE);
    load_out = (state == deq_pkg::S_LOAD) && (!m_tvalid || m_tready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= deq_pkg::S_IDLE;
      head   <= '0;
      count  <= '0;
      status <= deq_pkg::STAT_OK;
    end else begin
      state <= state_next;
      if (accept) begin
        head   <= head_next;
        count  <= count_next;
        status <= status_next;
      end
    end
  end

  deq_store #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .DW    (DW)
  ) u_store (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (din),
    .rd_addr_a (head),
    .rd_addr_b (back_slot),
    .rd_data_a (rd_front),
    .rd_data_b (rd_back)
  );

  // output register: holds one result while the next item is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_tdata <= {status, deq_pkg::COUNT_W'(count), empty,
                  empty ? {DW{1'b0}} : rd_back, empty ? {DW{1'b0}} : rd_front};
    end
  end

endmodule

// ----- hdl/deq_checker.sv -----
`include "double_ended_queue_macros.svh"

module deq_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tvalid,
  input logic                            s_tready,
  input logic [deq_pkg::OUT_TDATA_W-1:0] m_tdata,
  input logic                            m_tvalid,
  input logic                            m_tready
);

  logic        res_empty;
  logic [4:0]  res_count;
  logic [1:0]  res_status;
  logic [63:0] res_values;

  assign res_empty  = m_tdata[64];
  assign res_count  = m_tdata[69:65];
  assign res_status = m_tdata[71:70];
  assign res_values = m_tdata[63:0];

  // a stalled result holds
  `DEQ_ASSERT_NXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

  // empty result carries zero count and zero values
  `DEQ_ASSERT_IMP(a_empty_zero, clk, rst, m_tvalid && res_empty, res_count == '0 && res_values == '0)

  // overflow only happens on a full, hence non-empty, queue
  `DEQ_ASSERT_IMP(a_ovf_nonempty, clk, rst, m_tvalid && res_status == deq_pkg::STAT_OVERFLOW, !res_empty)

  // one item at a time: no accept right after an accept
  `DEQ_ASSERT_NXT(a_one_at_a_time, clk, rst, s_tvalid && s_tready, !s_tready)

endmodule

bind double_ended_queue deq_checker u_deq_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tdata  (m_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready)
);
